// File: rtl/core/capture_period_tachometer_defines.svh
// Assertion macros shared by the tachometer RTL.
// Needs clk and arst_n in the scope of each use; no other dependencies.
`ifndef CAPTURE_PERIOD_TACHOMETER_DEFINES_SVH
`define CAPTURE_PERIOD_TACHOMETER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define CPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cpt_pkg.sv
// Shared types and constants for the capture period tachometer.
// No dependencies; used by the stream interface instances and the top level.
package cpt_pkg;

	localparam int NUM_CHANNELS_DEF = 2;

	localparam int STAMP_W  = 16;
	localparam int SUM_W    = 32;
	localparam int COUNT_W  = 16;
	localparam int NUM_W    = 32;
	localparam int PPR_W    = 10;
	localparam int PROD_W   = STAMP_W + PPR_W;
	localparam int DIV_W    = 32;
	localparam int STEP_W   = $clog2(DIV_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RPM_NUM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PPR     = 2'd1;

	localparam logic [NUM_W-1:0] RPM_NUM_RESET = 32'd60000000;
	localparam logic [PPR_W-1:0] PPR_RESET     = 10'd28;

	typedef struct packed {
		logic               channel;
		logic [STAMP_W-1:0] stamp;
	} cpt_in_t;

	typedef struct packed {
		logic               out_channel;
		logic [STAMP_W-1:0] avg_period;
		logic [NUM_W-1:0]   rpm;
		logic               rpm_valid;
	} cpt_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [NUM_W-1:0]     data;
	} cpt_cfg_t;

endpackage

// File: rtl/core/cpt_stream_if.sv
// Valid/ready stream channel carrying one word of a chosen type.
// Word types come from cpt_pkg at the point of instantiation.
interface cpt_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

// File: rtl/core/capture_period_tachometer.sv
// Two-channel encoder tachometer: running mean period and rpm from capture stamps.
// Depends on cpt_pkg, cpt_stream_if and capture_period_tachometer_defines.svh.
//
//   port      dir     word        notes
//   capture   sink    cpt_in_t    channel + timer stamp
//   result    source  cpt_out_t   avg_period, rpm, rpm_valid
//   cfg       sink    cpt_cfg_t   index 0 rpm_numerator, 1 edges per revolution
//
// Each word makes up to two 32-step passes of a single shared restoring
// divider (sum / count, then numerator / (avg * pulses)) with sequencing
// states between them; saturated, first-capture and zero-divisor words skip
// a pass. capture.ready is high only while the sequencer is idle. A finished
// word sits in the output register, so a stalled result only blocks the next
// word at its final step. Reset clears all channel state; cfg is always ready.
module capture_period_tachometer #(
	parameter int NUM_CHANNELS = cpt_pkg::NUM_CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cpt_stream_if.sink   capture,
	cpt_stream_if.source result,
	cpt_stream_if.sink   cfg
);
	import cpt_pkg::*;

	`include "capture_period_tachometer_defines.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV_AVG,
		S_MUL,
		S_CHK,
		S_DIV_RPM,
		S_DONE
	} state_t;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

	state_t state_q;

	// configuration
	logic [NUM_W-1:0] num_q;
	logic [PPR_W-1:0] ppr_q;

	// per-channel state
	logic [STAMP_W-1:0] last_stamp_q [NUM_CHANNELS];
	logic [SUM_W-1:0]   period_sum_q [NUM_CHANNELS];
	logic [COUNT_W-1:0] count_q      [NUM_CHANNELS];
	logic [STAMP_W-1:0] held_avg_q   [NUM_CHANNELS];

	// working registers
	logic               ch_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] avg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [NUM_W-1:0]   rpm_q;
	logic               rpm_ok_q;

	// shared divider
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;

	// output register
	logic     out_valid_q;
	cpt_out_t out_word_q;

	logic               in_range;
	logic [STAMP_W-1:0] cur_last;
	logic [SUM_W-1:0]   cur_sum;
	logic [COUNT_W-1:0] cur_cnt;
	logic [STAMP_W-1:0] cur_held;
	logic [STAMP_W-1:0] period;
	logic [DIV_W:0]     trial;
	logic [DIV_W:0]     diff;
	logic               ge;
	logic [DIV_W-1:0]   rem_next;
	logic [DIV_W-1:0]   quo_next;

	assign capture.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign result.valid  = out_valid_q;
	assign result.word   = out_word_q;

	// select the captured channel's state
	always_comb begin
		in_range = (int'(ch_q) < NUM_CHANNELS);
		cur_last = '0;
		cur_sum  = '0;
		cur_cnt  = '0;
		cur_held = '0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			if (int'(ch_q) == k) begin
				cur_last = last_stamp_q[k];
				cur_sum  = period_sum_q[k];
				cur_cnt  = count_q[k];
				cur_held = held_avg_q[k];
			end
		end
		period = stamp_q - cur_last;
	end

	// one restoring-division step
	always_comb begin
		trial    = {rem_q, quo_q[DIV_W-1]};
		diff     = trial - {1'b0, dvs_q};
		ge       = (trial >= {1'b0, dvs_q});
		rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		quo_next = {quo_q[DIV_W-2:0], ge};
	end

	// sequencer, channel state, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_q       <= RPM_NUM_RESET;
			ppr_q       <= PPR_RESET;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				last_stamp_q[k] <= '0;
				period_sum_q[k] <= '0;
				count_q[k]      <= '0;
				held_avg_q[k]   <= '0;
			end
		end else begin
			if (cfg.valid) begin
				unique case (cfg.word.index)
					REG_RPM_NUM: num_q <= cfg.word.data;
					REG_PPR:     ppr_q <= cfg.word.data[PPR_W-1:0];
					default: ;
				endcase
			end

			// output register drains; S_DONE reloads it on its own
			if (out_valid_q && result.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (capture.valid) begin
						ch_q    <= capture.word.channel;
						stamp_q <= capture.word.stamp;
						state_q <= S_PREP;
					end
				end

				// period, state update, choose how the average is formed
				S_PREP: begin
					for (int k = 0; k < NUM_CHANNELS; k++) begin
						if (in_range && int'(ch_q) == k) begin
							last_stamp_q[k] <= stamp_q;
							if (cur_cnt != COUNT_MAX)
								count_q[k] <= cur_cnt + 1'b1;
							if (cur_cnt != '0 && cur_cnt != COUNT_MAX)
								period_sum_q[k] <= cur_sum + SUM_W'(period);
						end
					end
					priority if (!in_range) begin
						avg_q   <= '0;
						state_q <= S_MUL;
					end else if (cur_cnt == '0) begin
						avg_q   <= period;
						state_q <= S_MUL;
					end else if (cur_cnt == COUNT_MAX) begin
						avg_q   <= cur_held;
						state_q <= S_MUL;
					end else begin
						rem_q   <= '0;
						quo_q   <= cur_sum + SUM_W'(period);
						dvs_q   <= DIV_W'(cur_cnt);
						step_q  <= '0;
						state_q <= S_DIV_AVG;
					end
				end

				S_DIV_AVG: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						avg_q   <= quo_next[STAMP_W-1:0];
						state_q <= S_MUL;
					end
				end

				// rpm divisor; also records the average for saturation
				S_MUL: begin
					prod_q <= PROD_W'(avg_q) * PROD_W'(ppr_q);
					for (int k = 0; k < NUM_CHANNELS; k++) begin
						if (in_range && int'(ch_q) == k)
							held_avg_q[k] <= avg_q;
					end
					state_q <= S_CHK;
				end

				S_CHK: begin
					if (prod_q == '0) begin
						rpm_q    <= '0;
						rpm_ok_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						rem_q   <= '0;
						quo_q   <= num_q;
						dvs_q   <= DIV_W'(prod_q);
						step_q  <= '0;
						state_q <= S_DIV_RPM;
					end
				end

				S_DIV_RPM: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						rpm_q    <= quo_next;
						rpm_ok_q <= 1'b1;
						state_q  <= S_DONE;
					end
				end

				// hand the word to the output register once it is free
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q            <= 1'b1;
						out_word_q.out_channel <= ch_q;
						out_word_q.avg_period  <= avg_q;
						out_word_q.rpm         <= rpm_q;
						out_word_q.rpm_valid   <= rpm_ok_q;
						state_q                <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CPT_ASSERT_NEXT(a_busy_after_accept, capture.valid && capture.ready, !capture.ready,
		"capture ready right after an accepted word")
	`CPT_ASSERT_NOW(a_div_rem_bound, state_q == S_DIV_AVG || state_q == S_DIV_RPM,
		rem_q < dvs_q, "divider remainder not below divisor")
	`CPT_ASSERT_NOW(a_valid_needs_avg, result.valid && result.word.rpm_valid,
		result.word.avg_period != '0, "rpm marked valid with zero average")
	`CPT_ASSERT_NOW(a_invalid_rpm_zero, result.valid && !result.word.rpm_valid,
		result.word.rpm == '0, "rpm nonzero while marked invalid")

endmodule
